/* rtl/core/ilf_pkg.sv */
// Shared types and constants for the IPv4 longest-prefix-match forwarder.
`default_nettype none
package ilf_pkg;
  localparam logic [1:0] REQ_ROUTE = 2'd0;
  localparam logic [1:0] REQ_ARP = 2'd1;
  localparam logic [1:0] REQ_FWD = 2'd2;

  localparam logic [2:0] ST_STORED = 3'd0;
  localparam logic [2:0] ST_TTL = 3'd1;
  localparam logic [2:0] ST_UNREACH = 3'd2;
  localparam logic [2:0] ST_DEFAULT = 3'd3;
  localparam logic [2:0] ST_DIRECT = 3'd4;
  localparam logic [2:0] ST_GW_MAC = 3'd5;
  localparam logic [2:0] ST_GW_NOMAC = 3'd6;
  localparam logic [2:0] ST_FULL = 3'd7;

  typedef struct packed {
    logic [1:0] req_type;
    logic [31:0] addr;
    logic [5:0] prefix_len;
    logic [31:0] gateway_addr;
    logic [3:0] iface;
    logic [47:0] mac_in;
    logic [7:0] ttl_in;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [31:0] next_hop;
    logic [3:0] out_iface;
    logic [47:0] mac_out;
    logic [7:0] ttl_out;
  } rsp_t;

  // Token that walks the route chain.
  typedef struct packed {
    logic vld;
    logic [1:0] op;
    logic [31:0] key;
    logic [5:0] len;
    logic [31:0] gw;
    logic [3:0] ifc;
    logic hit;
    logic [5:0] best_len;
    logic [31:0] best_gw;
    logic [3:0] best_ifc;
    logic claimed;
  } rtok_t;

  // Token that walks the ARP chain.
  typedef struct packed {
    logic vld;
    logic [1:0] op;
    logic [31:0] key;
    logic [47:0] mac;
    logic hit;
    logic [47:0] hit_mac;
    logic claimed;
  } atok_t;

  typedef enum logic [2:0] {
    S_IDLE, S_ROUTE, S_ARP, S_DONE
  } state_t;

  function automatic logic [31:0] len_mask(input logic [5:0] len);
    logic [31:0] m;
    m = '0;
    for (int i = 0; i < 32; i++) begin
      if (32 - i <= int'(len)) m[i] = 1'b1;
    end
    return m;
  endfunction
endpackage
`default_nettype wire

/* rtl/core/ilf_if.sv */
// Valid/ready channel interfaces for requests and results.
`default_nettype none
interface ilf_req_if import ilf_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface ilf_rsp_if import ilf_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/core/ilf_route_cell.sv */
// One route table entry that updates or matches a passing token.
`default_nettype none
module ilf_route_cell import ilf_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire rtok_t tin,
  output rtok_t tout
);
  logic valid;
  logic [31:0] prefix;
  logic [5:0] length;
  logic [31:0] gw;
  logic [3:0] ifc;
  rtok_t t;
  logic same, take, match;

  always_comb begin
    t = tin;
    same = valid && length == tin.len && prefix == tin.key;
    take = tin.vld && tin.op == REQ_ROUTE && !tin.hit && !tin.claimed && !valid;
    match = valid && length > tin.best_len &&
            (tin.key & len_mask(length)) == prefix;
    if (tin.vld && tin.op == REQ_ROUTE && same && !tin.hit) t.hit = 1'b1;
    if (take) t.claimed = 1'b1;
    if (tin.vld && tin.op == REQ_FWD && match) begin
      t.hit = 1'b1;
      t.best_len = length;
      t.best_gw = gw;
      t.best_ifc = ifc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      tout.vld <= 1'b0;
    end else begin
      tout <= t;
      if (take) valid <= 1'b1;
    end
    if (tin.vld && tin.op == REQ_ROUTE && !tin.hit && (same || take)) begin
      gw <= tin.gw;
      ifc <= tin.ifc;
      if (take) begin
        prefix <= tin.key;
        length <= tin.len;
      end
    end
  end
endmodule
`default_nettype wire

/* rtl/core/ilf_arp_cell.sv */
// One ARP entry that stores or matches a passing token.
`default_nettype none
module ilf_arp_cell import ilf_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire atok_t tin,
  output atok_t tout
);
  logic valid;
  logic [31:0] ip;
  logic [47:0] mac;
  atok_t t;
  logic take, same;

  always_comb begin
    t = tin;
    same = valid && ip == tin.key;
    take = tin.vld && tin.op == REQ_ARP && !tin.hit && !tin.claimed && !valid;
    if (tin.vld && same && !tin.hit) begin
      t.hit = 1'b1;
      t.hit_mac = mac;
    end
    if (take) t.claimed = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      tout.vld <= 1'b0;
    end else begin
      tout <= t;
      if (take) valid <= 1'b1;
    end
    if (take) begin
      ip <= tin.key;
      mac <= tin.mac;
    end
  end
endmodule
`default_nettype wire

/* rtl/core/ipv4_lpm_forwarder.sv */
// Top level: request control, route cell chain, ARP cell chain, result register.
`default_nettype none
// One item at a time. An add-route with a nonzero prefix length or a forward
// with a TTL above 1 enters the route chain of ROUTE_ENTRIES cells and moves
// one cell per cycle. An add-ARP, and a forward whose best route has a gateway,
// then traverses the ARP chain of ARP_ENTRIES cells, one cell per cycle. A TTL
// discard, a default route setting and an unknown request pass neither chain.
// The next request is taken once the result is loaded into the output register,
// while the result waits there; a finished item whose result cannot be loaded
// because the previous one is still waiting holds the block.
module ipv4_lpm_forwarder import ilf_pkg::*; #(
  parameter int ROUTE_ENTRIES = 64,
  parameter int ARP_ENTRIES = 64
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic cfg_we,
  input wire logic [3:0] cfg_wdata,
  ilf_req_if.sink req,
  ilf_rsp_if.source rsp
);
  state_t state, state_next;
  logic [3:0] default_interface;
  logic default_valid;
  logic [31:0] fallback_gw;
  req_t cur;
  rtok_t rchain [ROUTE_ENTRIES+1];
  atok_t achain [ARP_ENTRIES+1];
  rtok_t rres;
  logic [47:0] gw_mac;
  logic rsp_valid;
  rsp_t rsp_data, res_next;
  logic fire, launch_r, launch_a, done_r, done_a, finish;
  logic [5:0] len_c;
  logic [7:0] ttl_m1;

  assign fire = req.valid && req.ready;
  assign req.ready = state == S_IDLE;
  assign rsp.valid = rsp_valid;
  assign rsp.data = rsp_data;
  assign len_c = (req.data.prefix_len > 6'd32) ? 6'd32 : req.data.prefix_len;
  assign ttl_m1 = cur.ttl_in - 8'd1;
  assign done_r = rchain[ROUTE_ENTRIES].vld;
  assign done_a = achain[ARP_ENTRIES].vld;

  always_comb begin
    rchain[0] = '0;
    rchain[0].vld = fire && req.data.req_type == REQ_ROUTE && len_c != 6'd0;
    rchain[0].op = req.data.req_type;
    rchain[0].key = req.data.addr & len_mask(len_c);
    rchain[0].len = len_c;
    rchain[0].gw = req.data.gateway_addr;
    rchain[0].ifc = req.data.iface;
    if (fire && req.data.req_type == REQ_FWD && req.data.ttl_in > 8'd1) begin
      rchain[0].vld = 1'b1;
      rchain[0].key = req.data.addr;
    end
    launch_r = rchain[0].vld;
  end

  for (genvar i = 0; i < ROUTE_ENTRIES; i++) begin : g_route
    ilf_route_cell u_cell (.clk(clk), .rst(rst), .tin(rchain[i]), .tout(rchain[i+1]));
  end
  for (genvar j = 0; j < ARP_ENTRIES; j++) begin : g_arp
    ilf_arp_cell u_cell (.clk(clk), .rst(rst), .tin(achain[j]), .tout(achain[j+1]));
  end

  always_comb begin
    achain[0] = '0;
    launch_a = 1'b0;
    if (state == S_IDLE && fire && req.data.req_type == REQ_ARP) begin
      launch_a = 1'b1;
      achain[0].op = REQ_ARP;
      achain[0].key = req.data.addr;
      achain[0].mac = req.data.mac_in;
    end else if (state == S_ROUTE && done_r && rchain[ROUTE_ENTRIES].op == REQ_FWD &&
                 rchain[ROUTE_ENTRIES].hit && rchain[ROUTE_ENTRIES].best_gw != '0) begin
      launch_a = 1'b1;
      achain[0].op = REQ_FWD;
      achain[0].key = rchain[ROUTE_ENTRIES].best_gw;
    end
    achain[0].vld = launch_a;
  end

  always_comb begin
    state_next = state;
    res_next = '0;
    finish = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (fire) begin
          if (launch_r) state_next = S_ROUTE;
          else if (launch_a) state_next = S_ARP;
          else state_next = S_DONE;
        end
      end
      S_ROUTE: begin
        if (done_r) begin
          if (launch_a) state_next = S_ARP;
          else state_next = S_DONE;
        end
      end
      S_ARP: if (done_a) state_next = S_DONE;
      S_DONE: begin
        finish = !rsp_valid || rsp.ready;
        if (finish) state_next = S_IDLE;
        unique case (cur.req_type)
          REQ_ROUTE: res_next.status = (rres.vld && !rres.hit && !rres.claimed) ?
                                       ST_FULL : ST_STORED;
          REQ_ARP: res_next.status = (rres.hit || rres.claimed) ? ST_STORED : ST_FULL;
          REQ_FWD: begin
            if (cur.ttl_in <= 8'd1) res_next.status = ST_TTL;
            else if (!rres.hit) begin
              if (default_valid) begin
                res_next.status = ST_DEFAULT;
                res_next.next_hop = fallback_gw;
                res_next.out_iface = default_interface;
                res_next.ttl_out = ttl_m1;
              end else res_next.status = ST_UNREACH;
            end else begin
              res_next.out_iface = rres.best_ifc;
              res_next.ttl_out = ttl_m1;
              if (rres.best_gw == '0) res_next.status = ST_DIRECT;
              else begin
                res_next.next_hop = rres.best_gw;
                res_next.status = rres.claimed ? ST_GW_MAC : ST_GW_NOMAC;
                if (rres.claimed) res_next.mac_out = gw_mac;
              end
            end
          end
          default: res_next = '0;
        endcase
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rsp_valid <= 1'b0;
      default_interface <= '0;
      default_valid <= 1'b0;
      fallback_gw <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) default_interface <= cfg_wdata;
      if (finish) rsp_valid <= 1'b1;
      else if (rsp.ready) rsp_valid <= 1'b0;
      if (fire && req.data.req_type == REQ_ROUTE && len_c == 6'd0 &&
          req.data.addr == '0) begin
        default_valid <= 1'b1;
        fallback_gw <= req.data.gateway_addr;
      end
    end
    if (fire) begin
      cur <= req.data;
      rres <= '0;
    end
    if (state == S_ROUTE && done_r) rres <= rchain[ROUTE_ENTRIES];
    if (state == S_ARP && done_a) begin
      gw_mac <= achain[ARP_ENTRIES].hit_mac;
      if (achain[ARP_ENTRIES].op == REQ_ARP) begin
        rres.hit <= achain[ARP_ENTRIES].hit;
        rres.claimed <= achain[ARP_ENTRIES].claimed;
      end else rres.claimed <= achain[ARP_ENTRIES].hit;
    end
    if (finish) rsp_data <= res_next;
  end

  assert property (@(posedge clk) disable iff (rst) req.ready |-> state == S_IDLE);
  assert property (@(posedge clk) disable iff (rst) finish |=> rsp_valid)
    else $error("result lost");
  assert property (@(posedge clk) disable iff (rst) rsp_valid && !rsp.ready |=> $stable(rsp_data))
    else $error("result changed while held");
  assert property (@(posedge clk) disable iff (rst) launch_a |-> !done_a)
    else $error("ARP chain overlap");
endmodule
`default_nettype wire

/* dv/tb_ipv4_lpm_forwarder.sv */
// Testbench for the IPv4 longest-prefix-match forwarder with a self-checking route/ARP predictor.
module tb_ipv4_lpm_forwarder;
  timeunit 1ns;
  timeprecision 1ps;
  import ilf_pkg::*;

  localparam int NROUTE = 64;
  localparam int NARP = 64;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [3:0] cfg_wdata = '0;

  ilf_req_if req_ch();
  ilf_rsp_if rsp_ch();

  ipv4_lpm_forwarder i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .req(req_ch.sink), .rsp(rsp_ch.source)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic [3:0] dflt_iface;
  logic rt_vld [NROUTE];
  logic [31:0] rt_pfx [NROUTE];
  logic [5:0] rt_len [NROUTE];
  logic [31:0] rt_gw [NROUTE];
  logic [3:0] rt_ifc [NROUTE];
  logic arp_vld [NARP];
  logic [31:0] arp_ipa [NARP];
  logic [47:0] arp_maca [NARP];
  logic dgw_vld;
  logic [31:0] dgw;

  rsp_t expected_rsps[$];
  int mismatches = 0;
  bit draining = 1'b0;

  function automatic logic [31:0] prefix_mask(int len);
    if (len <= 0) return 32'h0;
    if (len >= 32) return 32'hFFFF_FFFF;
    return 32'hFFFF_FFFF << (32 - len);
  endfunction

  function automatic rsp_t forward_lookup(req_t r);
    rsp_t o;
    int best, best_len, len;
    logic [31:0] pfx;
    int freei;
    o = '0;
    o.status = ST_STORED;
    case (r.req_type)
      REQ_ROUTE: begin
        len = (r.prefix_len > 32) ? 32 : r.prefix_len;
        if (len == 0) begin
          if (r.addr == 0) begin
            dgw_vld = 1'b1;
            dgw = r.gateway_addr;
          end
        end else begin
          pfx = r.addr & prefix_mask(len);
          freei = -1;
          best = -1;
          for (int i = 0; i < NROUTE; i++) begin
            if (rt_vld[i]) begin
              if (best < 0 && rt_len[i] == len && rt_pfx[i] == pfx) best = i;
            end else if (freei < 0) freei = i;
          end
          if (best >= 0) begin
            rt_gw[best] = r.gateway_addr;
            rt_ifc[best] = r.iface;
          end else if (freei < 0) o.status = ST_FULL;
          else begin
            rt_vld[freei] = 1'b1;
            rt_pfx[freei] = pfx;
            rt_len[freei] = len[5:0];
            rt_gw[freei] = r.gateway_addr;
            rt_ifc[freei] = r.iface;
          end
        end
      end
      REQ_ARP: begin
        freei = -1;
        best = -1;
        for (int i = 0; i < NARP; i++) begin
          if (arp_vld[i]) begin
            if (arp_ipa[i] == r.addr) best = i;
          end else if (freei < 0) freei = i;
        end
        if (best < 0) begin
          if (freei < 0) o.status = ST_FULL;
          else begin
            arp_vld[freei] = 1'b1;
            arp_ipa[freei] = r.addr;
            arp_maca[freei] = r.mac_in;
          end
        end
      end
      REQ_FWD: begin
        if (r.ttl_in <= 1) o.status = ST_TTL;
        else begin
          best = -1;
          best_len = 0;
          for (int i = 0; i < NROUTE; i++)
            if (rt_vld[i] && rt_len[i] > best_len &&
                (r.addr & prefix_mask(rt_len[i])) == rt_pfx[i]) begin
              best = i;
              best_len = rt_len[i];
            end
          if (best < 0) begin
            if (dgw_vld) begin
              o.status = ST_DEFAULT;
              o.next_hop = dgw;
              o.out_iface = dflt_iface;
              o.ttl_out = r.ttl_in - 8'd1;
            end else o.status = ST_UNREACH;
          end else if (rt_gw[best] == 0) begin
            o.status = ST_DIRECT;
            o.out_iface = rt_ifc[best];
            o.ttl_out = r.ttl_in - 8'd1;
          end else begin
            o.status = ST_GW_NOMAC;
            o.next_hop = rt_gw[best];
            o.out_iface = rt_ifc[best];
            o.ttl_out = r.ttl_in - 8'd1;
            for (int i = NARP - 1; i >= 0; i--)
              if (arp_vld[i] && arp_ipa[i] == rt_gw[best]) begin
                o.status = ST_GW_MAC;
                o.mac_out = arp_maca[i];
              end
          end
        end
      end
      default: o = '0;
    endcase
    return o;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 200);
  endfunction

  task automatic send_req(req_t r);
    int g;
    g = gap_len();
    @(negedge clk);
    if (g > 0) begin
      req_ch.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    req_ch.data <= r;
    req_ch.valid <= 1'b1;
    do @(posedge clk); while (!req_ch.ready);
    expected_rsps.push_back(forward_lookup(r));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (expected_rsps.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_default_iface(logic [3:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    dflt_iface = v;
  endtask

  function automatic req_t mk(logic [1:0] t, logic [31:0] a, logic [5:0] l,
                               logic [31:0] g, logic [3:0] i, logic [47:0] m,
                               logic [7:0] ttl);
    req_t r;
    r.req_type = t; r.addr = a; r.prefix_len = l; r.gateway_addr = g;
    r.iface = i; r.mac_in = m; r.ttl_in = ttl;
    return r;
  endfunction

  function automatic req_t rand_req();
    req_t r;
    int p;
    logic [159:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    r = raw[131:0];
    p = $urandom_range(0, 99);
    r.addr = {8'd10, 8'($urandom_range(0, 3)), 16'($urandom)};
    if ($urandom_range(0, 9) == 0) r.addr = $urandom;
    r.gateway_addr = ($urandom_range(0, 3) == 0) ? 32'h0 :
                     {24'h0A0000, 8'($urandom_range(1, 6))};
    if ($urandom_range(0, 19) == 0) r.gateway_addr = $urandom;
    if (p < 25) begin
      r.req_type = REQ_ROUTE;
      r.prefix_len = $urandom_range(0, 10) == 0 ? 6'($urandom) : 6'($urandom_range(8, 24));
      if ($urandom_range(0, 19) == 0) r.addr = '0;
    end else if (p < 40) begin
      r.req_type = REQ_ARP;
      if ($urandom_range(0, 1)) r.addr = {24'h0A0000, 8'($urandom_range(1, 6))};
    end else if (p < 97) begin
      r.req_type = REQ_FWD;
      if ($urandom_range(0, 9) != 0) r.ttl_in = 8'($urandom_range(2, 255));
    end else r.req_type = 2'd3;
    return r;
  endfunction

  task automatic test_directed();
    send_req(mk(REQ_FWD, 32'h0A000001, '0, '0, '0, '0, 8'd64));
    send_req(mk(REQ_FWD, 32'h0A000001, '0, '0, '0, '0, 8'd0));
    send_req(mk(REQ_FWD, 32'h0A000001, '0, '0, '0, '0, 8'd1));
    send_req(mk(REQ_ROUTE, 32'h0, 6'd0, 32'hC0A80001, 4'd3, '0, '0));
    send_req(mk(REQ_FWD, 32'hFFFFFFFF, '0, '0, '0, '0, 8'd255));
    send_req(mk(REQ_ROUTE, 32'h0, 6'd0, 32'hC0A800FE, 4'd3, '0, '0));
    send_req(mk(REQ_ROUTE, 32'h01020304, 6'd0, 32'h1, 4'd1, '0, '0));
    send_req(mk(REQ_ROUTE, 32'h0A0102FF, 6'd8, 32'h0, 4'd2, '0, '0));
    send_req(mk(REQ_ROUTE, 32'h0A0102FF, 6'd16, 32'h0A000005, 4'd5, '0, '0));
    send_req(mk(REQ_ROUTE, 32'h0A0100FF, 6'd16, 32'h0A000006, 4'd6, '0, '0));
    send_req(mk(REQ_ROUTE, 32'hFFFFFFFF, 6'd63, 32'hFFFFFFFF, 4'hF, '0, '0));
    send_req(mk(REQ_ROUTE, 32'h80000000, 6'd1, 32'h0A000005, 4'd0, '0, '0));
    send_req(mk(REQ_FWD, 32'h0A010203, '0, '0, '0, '0, 8'd2));
    send_req(mk(REQ_ARP, 32'h0A000006, '0, '0, '0, 48'hFFFFFFFFFFFF, '0));
    send_req(mk(REQ_ARP, 32'h0A000006, '0, '0, '0, 48'h123456789ABC, '0));
    send_req(mk(REQ_FWD, 32'h0A010203, '0, '0, '0, '0, 8'd10));
    send_req(mk(REQ_FWD, 32'h0A220203, '0, '0, '0, '0, 8'd10));
    send_req(mk(REQ_FWD, 32'hFFFFFFFF, '0, '0, '0, '0, 8'd255));
    send_req(mk(REQ_FWD, 32'hF0000000, '0, '0, '0, '0, 8'd3));
    send_req(mk(REQ_FWD, 32'h01000000, '0, '0, '0, '0, 8'd3));
    send_req(mk(2'd3, 32'hFFFFFFFF, 6'h3F, 32'hFFFFFFFF, 4'hF, 48'hFFFFFFFFFFFF, 8'hFF));
  endtask

  task automatic test_random(int n);
    for (int k = 0; k < n; k++) send_req(rand_req());
  endtask

  task automatic test_table_full();
    for (int k = 0; k < NROUTE + 3; k++)
      send_req(mk(REQ_ROUTE, {8'd20, 8'(k), 16'($urandom)}, 6'd16, $urandom, 4'($urandom),
                  '0, '0));
    for (int k = 0; k < NARP + 3; k++)
      send_req(mk(REQ_ARP, {8'd30, 24'(k)}, '0, '0, '0, {$urandom, 16'($urandom)}, '0));
    for (int k = 0; k < 20; k++) begin
      req_t r;
      r = rand_req();
      r.req_type = REQ_FWD;
      send_req(r);
    end
  endtask

  always @(posedge clk) begin
    rsp_t exp_r;
    if (rsp_ch.valid && rsp_ch.ready && !rst) begin
      if (expected_rsps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", rsp_ch.data);
      end else begin
        exp_r = expected_rsps.pop_front();
        if (rsp_ch.data !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p actual %p", exp_r, rsp_ch.data);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst || draining) rsp_ch.ready <= 1'b1;
    else if ($urandom_range(0, 99) < 30) rsp_ch.ready <= ($urandom_range(0, 49) == 0) ? 1'b0 :
                                                       ($urandom_range(0, 2) != 0);
    else if ($urandom_range(0, 19) == 0) rsp_ch.ready <= 1'b0;
    else rsp_ch.ready <= 1'b1;
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    dflt_iface = '0;
    dgw_vld = 1'b0;
    dgw = '0;
    for (int i = 0; i < NROUTE; i++) rt_vld[i] = 1'b0;
    for (int i = 0; i < NARP; i++) arp_vld[i] = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    write_default_iface(4'hF);
    test_directed();
    wait_idle();
    write_default_iface(4'h0);
    test_random(200);
    wait_idle();
    write_default_iface(4'h9);
    test_random(80);
    test_table_full();
    draining = 1'b1;
    wait_idle();
    if (mismatches == 0 && expected_rsps.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
